FILE: src/aptq_pkg.sv
package aptq_pkg;

  // Default sizes of the task table.
  localparam int DEPTH_DEF     = 16;
  localparam int TAG_WIDTH_DEF = 8;

  // Fixed field widths.
  localparam int KIND_W    = 2;
  localparam int IN_PRIO_W = 8;
  localparam int PRIO_W    = 16;
  localparam int PHASE_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int STATUS_W  = 3;

  localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISP  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK  = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_STEP     = 1'd1;
  localparam logic [CFG_W-1:0]     AGE_INTERVAL_RST = 8'd2;
  localparam logic [CFG_W-1:0]     AGE_STEP_RST     = 8'd20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;       // capture request fields, restart sweep
    logic                step;       // read the slot at the index, advance it
    logic                enq_write;  // write the new task into the slot at the index
    logic                tick_mode;  // returning reads are aged, not compared
    logic                finish;     // register the result
    logic [STATUS_W-1:0] fin_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic free_here;
    logic last_idx;
  } stat_t;

endpackage

FILE: src/aptq_ram.sv
module aptq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/aptq_ctrl.sv
module aptq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [aptq_pkg::KIND_W-1:0] kind,
  input  aptq_pkg::stat_t             st,
  output aptq_pkg::cmd_t              cmd,
  output logic                        busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   op_tick, op_tick_next;

  assign busy = (state != S_IDLE);

  // Sequencing of enqueue search, dequeue search and aging sweep.
  always_comb begin
    state_next     = state;
    op_tick_next   = op_tick;
    cmd            = '0;
    cmd.tick_mode  = op_tick;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          op_tick_next = (kind == aptq_pkg::KIND_TICK);
          case (kind)
            aptq_pkg::KIND_ENQ: begin
              if (st.full) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = aptq_pkg::ST_FULL;
              end else begin
                state_next = S_FIND;
              end
            end
            aptq_pkg::KIND_DEQ: begin
              if (st.empty) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = aptq_pkg::ST_EMPTY;
              end else begin
                state_next = S_SWEEP;
              end
            end
            aptq_pkg::KIND_TICK: begin
              state_next = S_SWEEP;
            end
            default: begin
              // Reserved kind: no change, answered as a finished tick.
              cmd.finish     = 1'b1;
              cmd.fin_status = aptq_pkg::ST_TICK;
            end
          endcase
        end
      end
      S_FIND: begin
        if (st.free_here) begin
          cmd.enq_write  = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = aptq_pkg::ST_ENQ;
          state_next     = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (st.last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = op_tick ? aptq_pkg::ST_TICK : aptq_pkg::ST_DISP;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op_tick <= 1'b0;
    end else begin
      state   <= state_next;
      op_tick <= op_tick_next;
    end
  end

`ifndef SYNTHESIS
  // A new request is only taken while idle.
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !cmd.load)
    else $error("request loaded while busy");

  // A sweep always drains and finishes before the block is idle again.
  assert property (@(posedge clk) disable iff (rst) (state == S_DRAIN) |=> (state == S_FIN))
    else $error("sweep did not finish after drain");

  // The enqueue search only ends by writing a free slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) && cmd.finish |-> cmd.enq_write && st.free_here)
    else $error("enqueue finished without a free slot");
`endif

endmodule

FILE: src/aptq_dp.sv
module aptq_dp #(
  parameter int DEPTH     = aptq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = aptq_pkg::TAG_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  aptq_pkg::cmd_t                     cmd,
  output aptq_pkg::stat_t                    st,
  input  logic [aptq_pkg::IN_PRIO_W-1:0]     new_priority,
  input  logic [TAG_WIDTH-1:0]               task_tag,
  input  logic                               cfg_we,
  input  logic [aptq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aptq_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                               res_valid,
  output logic [aptq_pkg::STATUS_W-1:0]      res_status,
  output logic [TAG_WIDTH-1:0]               res_tag,
  output logic [aptq_pkg::PRIO_W-1:0]        res_priority,
  output logic [$clog2(DEPTH+1)-1:0]         res_occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PH_LO = 0;
  localparam int PR_LO = aptq_pkg::PHASE_W;
  localparam int TG_LO = aptq_pkg::PHASE_W + aptq_pkg::PRIO_W;
  localparam int RAM_W = TG_LO + TAG_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Configuration registers.
  logic [aptq_pkg::CFG_W-1:0] age_interval;
  logic [aptq_pkg::CFG_W-1:0] age_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_interval <= aptq_pkg::AGE_INTERVAL_RST;
      age_step     <= aptq_pkg::AGE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aptq_pkg::CFG_AGE_INTERVAL: age_interval <= cfg_wdata;
        aptq_pkg::CFG_AGE_STEP:     age_step     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Slot valid bits, occupancy and sweep pointer.
  logic [DEPTH-1:0] valid;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  // Captured request fields.
  logic [TAG_WIDTH-1:0]              tag_q;
  logic [aptq_pkg::IN_PRIO_W-1:0]    prio_q;

  // Best candidate of a dequeue search.
  logic                       best_found;
  logic [IDX_W-1:0]           best_idx;
  logic [TAG_WIDTH-1:0]       best_tag;
  logic [aptq_pkg::PRIO_W-1:0] best_prio;

  // Slot store: tag, current priority and aging phase.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;

  aptq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  logic [aptq_pkg::PHASE_W-1:0] rd_phase;
  logic [aptq_pkg::PRIO_W-1:0]  rd_prio;
  logic [TAG_WIDTH-1:0]         rd_tag;
  logic                         rd_live;

  assign rd_phase = ram_rdata[PH_LO +: aptq_pkg::PHASE_W];
  assign rd_prio  = ram_rdata[PR_LO +: aptq_pkg::PRIO_W];
  assign rd_tag   = ram_rdata[TG_LO +: TAG_WIDTH];
  assign rd_live  = rd_pend && valid[rd_idx];

  // Aging of the slot whose data has just returned.
  logic [aptq_pkg::PHASE_W-1:0] phase_inc;
  logic                         boost;
  logic [aptq_pkg::PRIO_W:0]    prio_sum;
  logic [aptq_pkg::PRIO_W-1:0]  prio_aged;
  logic [aptq_pkg::PHASE_W-1:0] phase_new;

  always_comb begin
    phase_inc = rd_phase + aptq_pkg::PHASE_W'(1);
    boost     = (phase_inc >= age_interval) || (phase_inc == '0);
    prio_sum  = {1'b0, rd_prio} + (aptq_pkg::PRIO_W + 1)'(age_step);
    if (!boost) begin
      prio_aged = rd_prio;
    end else if (prio_sum[aptq_pkg::PRIO_W]) begin
      prio_aged = aptq_pkg::PRIO_MAX;
    end else begin
      prio_aged = prio_sum[aptq_pkg::PRIO_W-1:0];
    end
    phase_new = boost ? '0 : phase_inc;
  end

  // Write port: new task on enqueue, aged entry during a tick sweep.
  always_comb begin
    if (cmd.enq_write) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = {tag_q, aptq_pkg::PRIO_W'(prio_q), aptq_pkg::PHASE_W'(0)};
    end else begin
      ram_we    = rd_live && cmd.tick_mode;
      ram_waddr = rd_idx;
      ram_wdata = {rd_tag, prio_aged, phase_new};
    end
  end

  // Status toward the controller.
  assign st.full      = (count == FULL_CNT);
  assign st.empty     = (count == '0);
  assign st.free_here = !valid[idx];
  assign st.last_idx  = (idx == LAST_IDX);

  logic disp;
  assign disp = cmd.finish && (cmd.fin_status == aptq_pkg::ST_DISP);

  always_comb begin
    count_next = count;
    if (cmd.enq_write) begin
      count_next = count + CNT_W'(1);
    end else if (disp) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Control state: valid bits, count, sweep pointer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      count      <= '0;
      idx        <= '0;
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      count     <= count_next;
      rd_pend   <= cmd.step;
      res_valid <= cmd.finish;
      if (cmd.enq_write) begin
        valid[idx] <= 1'b1;
      end
      if (disp) begin
        valid[best_idx] <= 1'b0;
      end
      if (cmd.load) begin
        idx        <= '0;
        best_found <= 1'b0;
      end else begin
        if (cmd.step) begin
          idx <= idx + IDX_W'(1);
        end
        if (rd_live && !cmd.tick_mode &&
            (!best_found || rd_prio > best_prio)) begin
          best_found <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_q  <= task_tag;
      prio_q <= new_priority;
    end
    if (cmd.step) begin
      rd_idx <= idx;
    end
    if (rd_live && !cmd.tick_mode && (!best_found || rd_prio > best_prio)) begin
      best_idx  <= rd_idx;
      best_tag  <= rd_tag;
      best_prio <= rd_prio;
    end
    if (cmd.finish) begin
      res_status    <= cmd.fin_status;
      res_tag       <= disp ? best_tag : '0;
      res_priority  <= disp ? best_prio : '0;
      res_occupancy <= count_next;
    end
  end

`ifndef SYNTHESIS
  // The occupancy count tracks the valid bits.
  assert property (@(posedge clk) disable iff (rst) count == CNT_W'($countones(valid)))
    else $error("occupancy count out of step with valid bits");

  // An enqueue never overwrites a waiting task.
  assert property (@(posedge clk) disable iff (rst) cmd.enq_write |-> !valid[idx])
    else $error("enqueue into an occupied slot");

  // A dispatch removes a waiting task that the search found.
  assert property (@(posedge clk) disable iff (rst) disp |-> best_found && valid[best_idx])
    else $error("dispatch without a valid candidate");
`endif

endmodule

FILE: src/aging_priority_task_queue_core.sv
// An enqueue into a full table finishes without a search; otherwise it makes a linear
// search for the lowest free slot. A dequeue or tick makes one pass over the slot RAM
// read port, then drains; an empty dequeue or reserved kind finishes without a pass.
// The result strobe done rises in the cycle after the work ends; busy is low again by then.
// Requests are handled one at a time, each taken only while idle; the receiver cannot stall.
// Reset (rst, synchronous) empties the table and restores age_interval 2 and age_step 20.
module aging_priority_task_queue_core #(
  parameter int DEPTH     = aptq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = aptq_pkg::TAG_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [aptq_pkg::KIND_W-1:0]    kind,
  input  logic [aptq_pkg::IN_PRIO_W-1:0] new_priority,
  input  logic [TAG_WIDTH-1:0]           task_tag,
  input  logic                           cfg_we,
  input  logic [aptq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aptq_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           done,
  output logic [aptq_pkg::STATUS_W-1:0]  status,
  output logic [TAG_WIDTH-1:0]           out_tag,
  output logic [aptq_pkg::PRIO_W-1:0]    out_priority,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy
);

  aptq_pkg::cmd_t  cmd;
  aptq_pkg::stat_t st;

  aptq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  aptq_dp #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .new_priority  (new_priority),
    .task_tag      (task_tag),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .res_valid     (done),
    .res_status    (status),
    .res_tag       (out_tag),
    .res_priority  (out_priority),
    .res_occupancy (occupancy)
  );

endmodule
